@@ design/lrec_pkg.sv @@
// Shared types, constants and helpers for the left-to-right expression calculator.
`timescale 1ns / 1ps

package lrec_pkg;

  // Arithmetic width of accumulator and operand
  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned CharWidth   = 8;
  localparam int unsigned ResultWidth = 32;

  // Command queue between front and back
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned QueuePtrW   = $clog2(QueueDepth);
  localparam int unsigned QueueCntW   = $clog2(QueueDepth + 1);

  // Output stream payload: result_value, bad_operator, divide_by_zero
  localparam int unsigned OutFieldW   = ResultWidth + 2;
  localparam int unsigned OutDataW    = ((OutFieldW + 7) / 8) * 8;

  // Divider step counter
  localparam int unsigned DivCntW     = $clog2(ValueWidth);

  // Character codes
  localparam logic [CharWidth-1:0] CharPlus  = 8'd43;
  localparam logic [CharWidth-1:0] CharMinus = 8'd45;
  localparam logic [CharWidth-1:0] CharStar  = 8'd42;
  localparam logic [CharWidth-1:0] CharSlash = 8'd47;
  localparam logic [CharWidth-1:0] CharEqual = 8'd61;
  localparam logic [CharWidth-1:0] CharSpace = 8'd32;
  localparam logic [CharWidth-1:0] CharZero  = 8'd48;

  typedef logic [ValueWidth-1:0] value_t;

  // Commands produced by the front end
  typedef enum logic [2:0] {
    CMD_ACC_DIGIT,
    CMD_OPER,
    CMD_OPND_DIGIT,
    CMD_APPLY,
    CMD_EMIT
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e              kind;
    logic [CharWidth-1:0]   ch;
  } cmd_t;

  // Divider request and status
  typedef struct packed {
    logic   start;
    value_t dividend;
    value_t divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // value*10 + (c - '0'), wrapping
  function automatic value_t fold_digit(value_t v, logic [CharWidth-1:0] c);
    return (v << 3) + (v << 1) + value_t'(c) - value_t'(CharZero);
  endfunction

  // Absolute value as unsigned; most negative maps to 2**(W-1)
  function automatic value_t magnitude(value_t v);
    return v[ValueWidth-1] ? (value_t'(0) - v) : v;
  endfunction

endpackage

@@ design/left_to_right_expression_calculator.sv @@
// Result path: the '=' transaction pushes an emit command into the queue; the back end
// pops it and loads the output register, which drives m_axis_tvalid.
// Throughput: one character per cycle while the command queue has room;
// a division holds the back end until the one-bit-per-cycle divider is done; the
// four-entry queue takes up to four commands meanwhile.
// Reset: asynchronous, active low; clears phase, queue, accumulator, flags, output reg.
`timescale 1ns / 1ps

module left_to_right_expression_calculator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [7:0] character
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [31:0] result_value, [32] bad_operator, [33] divide_by_zero, rest zero
  output logic [lrec_pkg::OutDataW-1:0]     m_axis_tdata
);

  logic                              push, q_full, q_empty, pop;
  lrec_pkg::cmd_t                    push_cmd, head;
  logic [lrec_pkg::ResultWidth-1:0]  res_value;
  logic                              res_bad, res_dz;

  lrec_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_char_i    (s_axis_tdata),
    .queue_full_i (q_full),
    .push_o       (push),
    .push_cmd_o   (push_cmd)
  );

  lrec_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .empty_o    (q_empty),
    .head_o     (head)
  );

  lrec_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .queue_empty_i  (q_empty),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_value_o    (res_value),
    .out_bad_op_o   (res_bad),
    .out_div_zero_o (res_dz)
  );

  assign m_axis_tdata = lrec_pkg::OutDataW'({res_dz, res_bad, res_value});

endmodule

@@ design/lrec_front.sv @@
// Front end: tracks the expression phase and turns characters into commands.
`timescale 1ns / 1ps

module lrec_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [lrec_pkg::CharWidth-1:0]  in_char_i,
  input  logic                            queue_full_i,
  output logic                            push_o,
  output lrec_pkg::cmd_t                  push_cmd_o
);

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_OPER,
    PH_SKIP,
    PH_OPND
  } phase_e;

  phase_e phase_q, phase_d;
  logic   accept;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Classify the character by phase
  always_comb begin
    phase_d         = phase_q;
    push_o          = 1'b0;
    push_cmd_o.kind = lrec_pkg::CMD_ACC_DIGIT;
    push_cmd_o.ch   = in_char_i;
    if (accept) begin
      unique case (phase_q)
        PH_FIRST: begin
          if (in_char_i == lrec_pkg::CharSpace) begin
            phase_d = PH_OPER;
          end else begin
            push_o = 1'b1;
          end
        end
        PH_OPER: begin
          push_o = 1'b1;
          if (in_char_i == lrec_pkg::CharEqual) begin
            push_cmd_o.kind = lrec_pkg::CMD_EMIT;
            phase_d         = PH_FIRST;
          end else begin
            push_cmd_o.kind = lrec_pkg::CMD_OPER;
            phase_d         = PH_SKIP;
          end
        end
        PH_SKIP: begin
          phase_d = PH_OPND;
        end
        PH_OPND: begin
          push_o = 1'b1;
          if (in_char_i == lrec_pkg::CharSpace) begin
            push_cmd_o.kind = lrec_pkg::CMD_APPLY;
            phase_d         = PH_OPER;
          end else begin
            push_cmd_o.kind = lrec_pkg::CMD_OPND_DIGIT;
          end
        end
        default: phase_d = PH_FIRST;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
    end else begin
      phase_q <= phase_d;
    end
  end

  // An equals sign in operator position always restarts the number phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && phase_q == PH_OPER && in_char_i == lrec_pkg::CharEqual)
      |=> (phase_q == PH_FIRST))
    else $error("front did not restart after end of expression");

endmodule

@@ design/lrec_queue.sv @@
// Small command queue between the front end and the execution back end.
`timescale 1ns / 1ps

module lrec_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lrec_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output lrec_pkg::cmd_t head_o
);

  lrec_pkg::cmd_t                   mem_q [lrec_pkg::QueueDepth];
  logic [lrec_pkg::QueuePtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [lrec_pkg::QueueCntW-1:0]   count_q;
  logic                             do_push, do_pop;

  assign full_o  = (count_q == lrec_pkg::QueueCntW'(lrec_pkg::QueueDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == lrec_pkg::QueuePtrW'(lrec_pkg::QueueDepth - 1)) ?
                    '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == lrec_pkg::QueuePtrW'(lrec_pkg::QueueDepth - 1)) ?
                    '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= lrec_pkg::QueueCntW'(lrec_pkg::QueueDepth))
    else $error("queue fill count overflow");

endmodule

@@ design/lrec_div.sv @@
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module lrec_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lrec_pkg::div_req_t  req_i,
  output lrec_pkg::div_stat_t stat_o,
  output lrec_pkg::value_t    quotient_o
);

  localparam int unsigned W = lrec_pkg::ValueWidth;

  logic                          busy_q, done_q;
  logic [lrec_pkg::DivCntW-1:0]  cnt_q;
  lrec_pkg::value_t              rem_q, quo_q, dvs_q;
  logic [W:0]                    shifted, trial;

  // Shift in the next dividend bit and try a subtract
  assign shifted = {rem_q, quo_q[W-1]};
  assign trial   = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == lrec_pkg::DivCntW'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= trial[W] ? shifted[W-1:0] : trial[W-1:0];
      quo_q <= {quo_q[W-2:0], ~trial[W]};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

@@ design/lrec_back.sv @@
// Back end: executes commands on the accumulator and holds the result register.
`timescale 1ns / 1ps

module lrec_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                queue_empty_i,
  input  lrec_pkg::cmd_t                      head_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [lrec_pkg::ResultWidth-1:0]    out_value_o,
  output logic                                out_bad_op_o,
  output logic                                out_div_zero_o
);

  typedef enum logic {
    ST_EXEC,
    ST_DIV
  } state_e;

  state_e                          state_q;
  lrec_pkg::value_t                acc_q, opnd_q;
  logic [lrec_pkg::CharWidth-1:0]  op_q;
  logic                            bad_q, dz_q, neg_q;
  logic                            out_valid_q;
  logic [lrec_pkg::ResultWidth-1:0] out_value_q;
  logic                            out_bad_q, out_dz_q;

  lrec_pkg::div_req_t              div_req;
  lrec_pkg::div_stat_t             div_stat;
  lrec_pkg::value_t                div_quo;
  logic                            slot_free, is_div;

  lrec_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .stat_o     (div_stat),
    .quotient_o (div_quo)
  );

  // Take a command unless a division is running, or, for an emit, while a result still waits
  assign slot_free = !out_valid_q || out_ready_i;
  assign pop_o     = (state_q == ST_EXEC) && !queue_empty_i &&
                     ((head_i.kind != lrec_pkg::CMD_EMIT) || slot_free);
  assign is_div    = pop_o && (head_i.kind == lrec_pkg::CMD_APPLY) &&
                     (op_q == lrec_pkg::CharSlash) && (opnd_q != '0);

  assign div_req.start    = is_div;
  assign div_req.dividend = lrec_pkg::magnitude(acc_q);
  assign div_req.divisor  = lrec_pkg::magnitude(opnd_q);

  // Command execution and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_EXEC;
      acc_q       <= '0;
      opnd_q      <= '0;
      op_q        <= '0;
      bad_q       <= 1'b0;
      dz_q        <= 1'b0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      out_bad_q   <= 1'b0;
      out_dz_q    <= 1'b0;
    end else begin
      // A new result replaces the one taken in the same cycle
      if (pop_o && head_i.kind == lrec_pkg::CMD_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_EXEC: begin
          if (pop_o) begin
            unique case (head_i.kind)
              lrec_pkg::CMD_ACC_DIGIT: acc_q <= lrec_pkg::fold_digit(acc_q, head_i.ch);
              lrec_pkg::CMD_OPER: begin
                op_q   <= head_i.ch;
                opnd_q <= '0;
              end
              lrec_pkg::CMD_OPND_DIGIT: opnd_q <= lrec_pkg::fold_digit(opnd_q, head_i.ch);
              lrec_pkg::CMD_APPLY: begin
                opnd_q <= '0;
                unique case (op_q)
                  lrec_pkg::CharPlus:  acc_q <= acc_q + opnd_q;
                  lrec_pkg::CharMinus: acc_q <= acc_q - opnd_q;
                  lrec_pkg::CharStar:  acc_q <= acc_q * opnd_q;
                  lrec_pkg::CharSlash: begin
                    if (opnd_q == '0) begin
                      dz_q <= 1'b1;
                    end else begin
                      neg_q   <= acc_q[lrec_pkg::ValueWidth-1] ^
                                 opnd_q[lrec_pkg::ValueWidth-1];
                      state_q <= ST_DIV;
                    end
                  end
                  default: bad_q <= 1'b1;
                endcase
              end
              lrec_pkg::CMD_EMIT: begin
                out_value_q <= lrec_pkg::ResultWidth'($signed(acc_q));
                out_bad_q   <= bad_q;
                out_dz_q    <= dz_q;
                acc_q       <= '0;
                opnd_q      <= '0;
                op_q        <= '0;
                bad_q       <= 1'b0;
                dz_q        <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            acc_q   <= neg_q ? (lrec_pkg::value_t'(0) - div_quo) : div_quo;
            state_q <= ST_EXEC;
          end
        end
        default: state_q <= ST_EXEC;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_value_o    = out_value_q;
  assign out_bad_op_o   = out_bad_q;
  assign out_div_zero_o = out_dz_q;

  // While waiting on the divider it must be working or just finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (div_stat.busy || div_stat.done))
    else $error("back end waits on an idle divider");

  // Emitting a result clears the expression state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && head_i.kind == lrec_pkg::CMD_EMIT)
      |=> (acc_q == '0 && !bad_q && !dz_q && out_valid_q))
    else $error("expression state not cleared after result");

endmodule

@@ tb/left_to_right_expression_calculator_test.sv @@
// Self-checking testbench for the left-to-right expression calculator.
`timescale 1ns / 1ps

module left_to_right_expression_calculator_test;
  import lrec_pkg::*;

  localparam int RandItems    = 700;     // random characters to send
  localparam int HoldCycles   = 400;     // long output hold-off
  localparam int SettleCycles = 200;     // room for a few queued divisions
  localparam int CycleLimit   = 400000;
  localparam int DirRows      = 4;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_OPER,
    PH_SKIP,
    PH_OPND
  } calc_phase_e;

  typedef struct packed {
    logic signed [ResultWidth-1:0] value;
    logic                          bad_op;
    logic                          div_zero;
  } calc_result_t;

  // DUT ports
  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [CharWidth-1:0] s_axis_tdata  = '0;  // [7:0] character
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // [31:0] result_value, [32] bad_operator, [33] divide_by_zero
  logic [OutDataW-1:0]  m_axis_tdata;

  // Run control and bookkeeping
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  bit hold_req  = 1'b0;
  int unsigned chars_sent       = 0;
  int unsigned results_checked  = 0;
  int unsigned bad_op_results   = 0;
  int unsigned div_zero_results = 0;
  int unsigned err_count        = 0;
  int unsigned cycle_count      = 0;

  logic [CharWidth-1:0] stim_q[$];
  calc_result_t         pending_results[$];
  calc_result_t         got_res, want_res;

  // Predictor state
  calc_phase_e          calc_phase;
  value_t               calc_acc;
  value_t               calc_opnd;
  logic [CharWidth-1:0] calc_op;
  logic                 calc_bad;
  logic                 calc_dz;

  // Directed expressions; typed results where they are obvious
  string dir_text [DirRows] = '{
    "= =",               // equals inside a number folds in as 13
    "9 /x0 %x3 =",       // zero divisor, then unknown operator
    "2147483648 / / =",  // most negative divided by -1 ('/' folds in as -1)
    "7 +-5 *x3 - 4 ="    // three operators, odd skip characters
  };
  bit dir_typed [DirRows] = '{1'b1, 1'b1, 1'b1, 1'b0};
  calc_result_t dir_result [DirRows] = '{
    '{value: 13, bad_op: 1'b0, div_zero: 1'b0},
    '{value: 9, bad_op: 1'b1, div_zero: 1'b1},
    '{value: 32'sh8000_0000, bad_op: 1'b0, div_zero: 1'b0},
    '{value: 0, bad_op: 1'b0, div_zero: 1'b0}
  };

  left_to_right_expression_calculator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---------------- predictor ----------------

  function automatic void calc_clear();
    calc_phase = PH_FIRST;
    calc_acc   = '0;
    calc_opnd  = '0;
    calc_op    = '0;
    calc_bad   = 1'b0;
    calc_dz    = 1'b0;
  endfunction

  // Decimal fold with wrap; any non-space character counts as (c - '0')
  function automatic value_t fold_char(value_t v, logic [CharWidth-1:0] c);
    return v * value_t'(10) + value_t'(c) - value_t'(CharZero);
  endfunction

  // Signed division truncating toward zero, done on magnitudes so that
  // most negative / -1 wraps instead of overflowing
  function automatic value_t div_toward_zero(value_t num, value_t den);
    value_t num_mag, den_mag, quo;
    num_mag = num[ValueWidth-1] ? -num : num;
    den_mag = den[ValueWidth-1] ? -den : den;
    quo     = num_mag / den_mag;
    return (num[ValueWidth-1] ^ den[ValueWidth-1]) ? -quo : quo;
  endfunction

  function automatic void calc_apply();
    case (calc_op)
      CharPlus:  calc_acc = calc_acc + calc_opnd;
      CharMinus: calc_acc = calc_acc - calc_opnd;
      CharStar:  calc_acc = calc_acc * calc_opnd;
      CharSlash: begin
        if (calc_opnd == '0) calc_dz = 1'b1;
        else calc_acc = div_toward_zero(calc_acc, calc_opnd);
      end
      default:   calc_bad = 1'b1;
    endcase
  endfunction

  // One character in; returns 1 with the expression result when '=' ends it
  function automatic bit calc_step(logic [CharWidth-1:0] c, output calc_result_t res);
    res = '0;
    case (calc_phase)
      PH_FIRST: begin
        if (c == CharSpace) calc_phase = PH_OPER;
        else calc_acc = fold_char(calc_acc, c);
      end
      PH_OPER: begin
        if (c == CharEqual) begin
          res.value    = ResultWidth'(signed'(calc_acc));
          res.bad_op   = calc_bad;
          res.div_zero = calc_dz;
          calc_clear();
          return 1'b1;
        end
        calc_op    = c;
        calc_phase = PH_SKIP;
      end
      PH_SKIP: begin
        calc_opnd  = '0;
        calc_phase = PH_OPND;
      end
      default: begin
        if (c == CharSpace) begin
          calc_apply();
          calc_opnd  = '0;
          calc_phase = PH_OPER;
        end else begin
          calc_opnd = fold_char(calc_opnd, c);
        end
      end
    endcase
    return 1'b0;
  endfunction

  // ---------------- stimulus generation ----------------

  function automatic logic [CharWidth-1:0] any_char();
    return CharWidth'($urandom_range(0, 255));
  endfunction

  // Mostly short numbers, sometimes long enough to wrap
  function automatic int unsigned number_len();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
  endfunction

  // Digits, with an occasional stray non-space character
  function automatic void push_number(int unsigned len);
    logic [CharWidth-1:0] c;
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        c = any_char();
        if (c == CharSpace) c = CharEqual;
      end else begin
        c = CharZero + CharWidth'($urandom_range(0, 9));
      end
      stim_q.push_back(c);
    end
  endfunction

  // Mostly well-formed expressions; some noise and some without '='
  function automatic void build_expression();
    int unsigned pick;
    logic [CharWidth-1:0] op;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 10)) stim_q.push_back(any_char());
      return;
    end
    push_number(number_len());
    stim_q.push_back(CharSpace);
    repeat ($urandom_range(0, 4)) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1:    op = CharPlus;
        2, 3:    op = CharMinus;
        4, 5:    op = CharStar;
        6, 7, 8: op = CharSlash;
        default: begin
          op = any_char();
          if (op == CharEqual) op = CharSpace;
        end
      endcase
      stim_q.push_back(op);
      stim_q.push_back($urandom_range(0, 1) ? CharSpace : any_char());
      // pick 8 forces a zero divisor: empty or all-zero operand
      if (pick == 8) repeat ($urandom_range(0, 2)) stim_q.push_back(CharZero);
      else push_number(number_len());
      stim_q.push_back(CharSpace);
    end
    if ($urandom_range(0, 11) != 0) stim_q.push_back(CharEqual);
  endfunction

  // ---------------- drivers ----------------

  // Offer one character, wait for the transaction, then update the predictor
  task automatic send_char(logic [CharWidth-1:0] c, bit typed, calc_result_t typed_res);
    calc_result_t res;
    if (send_idle && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    do @(posedge clk_i); while (!s_axis_tready);
    chars_sent++;
    if (calc_step(c, res)) pending_results.push_back(typed ? typed_res : res);
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // Output side: random stall bursts plus one long hold-off on request
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HoldCycles - 1;
        m_axis_tready <= 1'b0;
      end else if (recv_idle && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 7);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------- result checking ----------------

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_res.value    = m_axis_tdata[ResultWidth-1:0];
      got_res.bad_op   = m_axis_tdata[ResultWidth];
      got_res.div_zero = m_axis_tdata[ResultWidth+1];
      if (pending_results.size() == 0) begin
        err_count++;
        $display("%0t ns: result with none expected: value %0d bad_op %0b div_zero %0b",
                 $time, got_res.value, got_res.bad_op, got_res.div_zero);
      end else begin
        want_res = pending_results.pop_front();
        results_checked++;
        if (got_res.bad_op) bad_op_results++;
        if (got_res.div_zero) div_zero_results++;
        if (got_res.value !== want_res.value) begin
          err_count++;
          $display("%0t ns: result_value expected %0d, got %0d",
                   $time, want_res.value, got_res.value);
        end
        if (got_res.bad_op !== want_res.bad_op) begin
          err_count++;
          $display("%0t ns: bad_operator expected %0b, got %0b",
                   $time, want_res.bad_op, got_res.bad_op);
        end
        if (got_res.div_zero !== want_res.div_zero) begin
          err_count++;
          $display("%0t ns: divide_by_zero expected %0b, got %0b",
                   $time, want_res.div_zero, got_res.div_zero);
        end
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t ns: timeout after %0d cycles, %0d results outstanding",
             $time, cycle_count, pending_results.size());
    $display("== FAIL ==");
    $finish;
  end

  // ---------------- main sequence ----------------

  initial begin
    int unsigned rand_sent;
    bit hold_done, drain_done;
    calc_result_t no_res;
    rand_sent  = 0;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    no_res     = '0;
    calc_clear();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed expressions
    for (int r = 0; r < DirRows; r++) begin
      for (int i = 0; i < dir_text[r].len(); i++) begin
        send_char(dir_text[r][i], dir_typed[r], dir_result[r]);
      end
    end

    // Random expressions
    while (rand_sent < RandItems) begin
      build_expression();
      while (stim_q.size() != 0) begin
        send_char(stim_q.pop_front(), 1'b0, no_res);
        rand_sent++;
      end
      // output stalls for a long stretch while input keeps coming
      if (!hold_done && rand_sent >= 200) begin
        hold_done = 1'b1;
        hold_req  = 1'b1;
      end
      // input pauses until everything outstanding has come out
      if (!drain_done && rand_sent >= 450) begin
        drain_done = 1'b1;
        wait_results_drained();
      end
      if (rand_sent >= RandItems - 120) begin
        send_idle = 1'b0;
        recv_idle = 1'b0;
      end
    end

    wait_results_drained();
    repeat (SettleCycles) @(posedge clk_i);

    $display("Sent %0d characters; checked %0d expressions (%0d bad operator, %0d zero divisor).",
             chars_sent, results_checked, bad_op_results, div_zero_results);
    $display("Run included random stalls, a %0d-cycle output hold-off and a mid-run drain.",
             HoldCycles);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
